FILE: rtl/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg: shared types and constants of the UTF-8 stream decoder
// Payload structs, the queue entry format and the UTF-8 / UTF-16 constants.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0]  CONT_LO   = 8'h80;
    localparam logic [7:0]  CONT_HI   = 8'hBF;
    localparam logic [7:0]  LOW_E0    = 8'hA0;
    localparam logic [7:0]  HIGH_ED   = 8'h9F;
    localparam logic [7:0]  LOW_F0    = 8'h90;
    localparam logic [7:0]  HIGH_F4   = 8'h8F;
    localparam logic [20:0] REPL_CHAR = 21'h00FFFD;
    localparam logic [20:0] SUPP_BASE = 21'h010000;
    localparam logic [20:0] HI_SURR   = 21'h00D800;
    localparam logic [20:0] LO_SURR   = 21'h00DC00;
    localparam logic [20:0] MAX_POINT = 21'h10FFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } t_in;

    typedef struct packed {
        logic [20:0] code_unit;
        logic        malformed;
        logic        run_last;
    } t_out;

    // One queue entry: all results caused by one byte (one or two units).
    typedef struct packed {
        logic [20:0] unit0;
        logic        bad0;
        logic [20:0] unit1;
        logic        bad1;
        logic        two;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

FILE: rtl/u8d_front.sv
// ----------------------------------------------------------------------------
// u8d_front: byte classifier and sequence state
// Accepts one byte per beat, tracks the pending sequence and forms the
// one or two output units that the byte causes.
// ----------------------------------------------------------------------------
module u8d_front
    import u8d_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_take,
    input  t_in  i_data,
    input  logic i_cfg_we,
    input  logic i_cfg_fmt,
    output logic o_push,
    output t_job o_job
);

    logic [15:0] r_pp,   n_pp;
    logic [1:0]  r_need, n_need;
    logic [7:0]  r_lo,   n_lo;
    logic [7:0]  r_hi,   n_hi;
    logic        r_fmt;

    logic [20:0] p0, p1;
    logic        bad0, bad1;
    logic [1:0]  np;
    logic [20:0] voff;

    always_comb begin
        logic [7:0]  b;
        logic [21:0] cp;
        b      = i_data.in_byte;
        cp     = {r_pp, b[5:0]};
        n_pp   = r_pp;
        n_need = r_need;
        n_lo   = r_lo;
        n_hi   = r_hi;
        p0     = '0;
        p1     = '0;
        bad0   = 1'b0;
        bad1   = 1'b0;
        np     = 2'd0;
        if (r_need != 2'd0 && b >= r_lo && b <= r_hi) begin
            n_need = r_need - 2'd1;
            n_lo   = CONT_LO;
            n_hi   = CONT_HI;
            if (r_need == 2'd1) begin
                n_pp = '0;
                p0   = cp[20:0];
                np   = 2'd1;
            end else begin
                n_pp = cp[15:0];
            end
        end else begin
            // broken sequence: flag it, then reprocess the byte as a lead
            if (r_need != 2'd0) begin
                p0   = REPL_CHAR;
                bad0 = 1'b1;
                np   = 2'd1;
            end
            n_pp   = '0;
            n_need = 2'd0;
            n_lo   = CONT_LO;
            n_hi   = CONT_HI;
            unique case (b) inside
                [8'h00:8'h7F]: begin
                    if (np == 2'd0) p0 = {13'd0, b};
                    else            p1 = {13'd0, b};
                    np = np + 2'd1;
                end
                [8'hC2:8'hDF]: begin
                    n_need = 2'd1;
                    n_pp   = {11'd0, b[4:0]};
                end
                [8'hE0:8'hEF]: begin
                    n_need = 2'd2;
                    n_pp   = {12'd0, b[3:0]};
                    if (b == 8'hE0) n_lo = LOW_E0;
                    if (b == 8'hED) n_hi = HIGH_ED;
                end
                [8'hF0:8'hF4]: begin
                    n_need = 2'd3;
                    n_pp   = {13'd0, b[2:0]};
                    if (b == 8'hF0) n_lo = LOW_F0;
                    if (b == 8'hF4) n_hi = HIGH_F4;
                end
                default: begin
                    if (np == 2'd0) begin
                        p0   = REPL_CHAR;
                        bad0 = 1'b1;
                    end else begin
                        p1   = REPL_CHAR;
                        bad1 = 1'b1;
                    end
                    np = np + 2'd1;
                end
            endcase
        end
        // end of text with a sequence still open
        if (i_data.is_last && n_need != 2'd0) begin
            n_pp   = '0;
            n_need = 2'd0;
            n_lo   = CONT_LO;
            n_hi   = CONT_HI;
            if (np == 2'd0) begin
                p0   = REPL_CHAR;
                bad0 = 1'b1;
            end else begin
                p1   = REPL_CHAR;
                bad1 = 1'b1;
            end
            np = np + 2'd1;
        end
    end

    // Only a completed supplementary point can need a pair; it comes alone.
    assign voff = p0 - SUPP_BASE;

    always_comb begin
        o_job.unit0 = p0;
        o_job.bad0  = bad0;
        o_job.unit1 = p1;
        o_job.bad1  = bad1;
        o_job.two   = (np == 2'd2);
        if (r_fmt && np == 2'd1 && p0 >= SUPP_BASE) begin
            o_job.unit0 = HI_SURR + {11'd0, voff[19:10]};
            o_job.unit1 = LO_SURR + {11'd0, voff[9:0]};
            o_job.bad1  = bad0;
            o_job.two   = 1'b1;
        end
    end

    assign o_push = i_take && (np != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp   <= '0;
            r_need <= 2'd0;
            r_lo   <= CONT_LO;
            r_hi   <= CONT_HI;
            r_fmt  <= 1'b0;
        end else begin
            if (i_take) begin
                r_pp   <= n_pp;
                r_need <= n_need;
                r_lo   <= n_lo;
                r_hi   <= n_hi;
            end
            if (i_cfg_we) r_fmt <= i_cfg_fmt;
        end
    end

endmodule

FILE: rtl/u8d_queue.sv
// ----------------------------------------------------------------------------
// u8d_queue: result queue between front and back
// Small register FIFO of per-byte result groups.
// ----------------------------------------------------------------------------
module u8d_queue
    import u8d_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_head,
    output t_qstat o_stat
);

    t_job             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == QDEPTH[QAW:0]);
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

FILE: rtl/u8d_back.sv
// ----------------------------------------------------------------------------
// u8d_back: output sequencer
// Walks the units of the queue head, one per beat, and marks the last one.
// ----------------------------------------------------------------------------
module u8d_back
    import u8d_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_job   i_head,
    input  t_qstat i_stat,
    output logic   o_pop,
    output logic   o_valid,
    input  logic   i_ready,
    output t_out   o_data
);

    logic r_half;

    assign o_valid          = !i_stat.empty;
    assign o_data.code_unit = r_half ? i_head.unit1 : i_head.unit0;
    assign o_data.malformed = r_half ? i_head.bad1  : i_head.bad0;
    assign o_data.run_last  = r_half || !i_head.two;
    assign o_pop            = o_valid && i_ready && o_data.run_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 1'b0;
        end else if (o_valid && i_ready) begin
            r_half <= !o_data.run_last;
        end
    end

endmodule

FILE: rtl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder: UTF-8 to code points or UTF-16 units
// Stream decoder with U+FFFD replacement under the maximal-subpart rule.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data): one beat per byte,
//   is_last set on the final byte of a text.
//   Output channel (o_out_valid / i_out_ready / o_out_data): one beat per
//   code point or UTF-16 unit; run_last marks the final result of a byte.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): out_format,
//   always ready; write it only while the block is idle.
//   A result is written into the result queue when its byte is accepted.
//   Throughput: one byte per cycle while the queue is not full; a byte
//   that yields two results (a replacement plus a reprocessed lead, or a
//   surrogate pair) occupies the output for two beats. A four-entry result
//   queue between the decoder and the output sequencer absorbs such bursts.
//   When the receiver stalls, the queue fills and o_in_ready drops once it
//   holds four groups; bytes that only start a sequence never take a slot.
//   Reset empties the queue, clears any pending sequence and sets
//   out_format to code points.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
    import u8d_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data
);

    logic   take;
    logic   push;
    logic   pop;
    t_job   job;
    t_job   head;
    t_qstat qstat;

    // Hold input while the queue is full; config is always taken.
    assign o_in_ready  = !qstat.full;
    assign o_cfg_ready = 1'b1;
    assign take        = i_in_valid && o_in_ready;

    // Front: classify the byte, advance the sequence state.
    u8d_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_data    (i_in_data),
        .i_cfg_we  (i_cfg_valid),
        .i_cfg_fmt (i_cfg_data),
        .o_push    (push),
        .o_job     (job)
    );

    // Queue: decouple decoding from output stalls.
    u8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    // Back: emit the units of each group, one per beat.
    u8d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_stat  (qstat),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

FILE: rtl/u8d_checker.sv
// ----------------------------------------------------------------------------
// u8d_checker: port-level assertions for the UTF-8 stream decoder
// Watches the output channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module u8d_checker
    import u8d_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_repl_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.malformed |-> o_out_data.code_unit == REPL_CHAR)
        else $error("malformed result is not U+FFFD");

    a_mid_is_high_surr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.run_last && !o_out_data.malformed
        |-> o_out_data.code_unit >= HI_SURR && o_out_data.code_unit < LO_SURR)
        else $error("non-final good unit is not a high surrogate");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.code_unit <= MAX_POINT)
        else $error("result above U+10FFFF");

    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (.*);
